@@ rtl/midpoint_ellipse_quadrant_macros.svh @@
// Assertion macros used by the checker file of the ellipse quadrant block.
`ifndef MIDPOINT_ELLIPSE_QUADRANT_MACROS_SVH
`define MIDPOINT_ELLIPSE_QUADRANT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define MEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MEQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/meq_pkg.sv @@
// Shared types and constants of the midpoint ellipse quadrant block.
package meq_pkg;

    localparam int COORD_W      = 10;
    localparam int COORD_MAX    = (2 ** COORD_W) - 1;
    localparam int AXIS_MAX_DEF = 1023;
    localparam int AX2_W        = 2 * COORD_W;       // axis squared
    localparam int SQ_W         = 2 * (COORD_W + 1); // (2x+1)^2 or (y-1)^2
    localparam int MUL_W        = 24;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DEC_W        = 48;

    typedef struct packed {
        logic                 start_req;
        logic [COORD_W-1:0]   semi_axis_x;
        logic [COORD_W-1:0]   semi_axis_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0]   point_x;
        logic [COORD_W-1:0]   point_y;
        logic                 last;
    } t_out_item;

    // What to do with a product in the cycle after it is issued
    typedef enum logic [3:0] {
        WB_NONE,
        WB_A2,
        WB_B2,
        WB_DEC_INIT,
        WB_TMP,
        WB_DEC_NEG4,
        WB_DEC_ADD,
        WB_DEC_ADD4,
        WB_SQ
    } t_wb;

    typedef struct packed {
        logic signed [MUL_W-1:0] op_a;
        logic signed [MUL_W-1:0] op_b;
        t_wb                     tag;
    } t_mul_req;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        t_wb                      tag;
    } t_mul_rsp;

endpackage

@@ rtl/midpoint_ellipse_quadrant.sv @@
// Top level of the midpoint ellipse quadrant point generator.
// Walks the first quadrant of an origin-centred ellipse with the two-region
// midpoint algorithm and returns one point for every input transfer. A
// transfer with start_req set latches the semi-axes (clipped to AXIS_MAX,
// and never above 1023) and returns (0, b); every other transfer returns the
// next point, stepping x+1 or diagonally in region 1 and y-1 or diagonally in
// region 2. The point that reaches y = 0 carries last; further advances
// repeat it with last set, and after reset an advance returns (0, 0) with
// last. The decision value is held exactly as a 48-bit integer, four times
// the textbook value. All products (axis squares, slope test, step updates,
// region-2 reload) go through one 24x24 multiplier, at most one product per cycle,
// under a small sequencer; the input stalls from the accepting edge until the
// result is handed to the output register. A finished point waits in a
// one-entry output register, so the next input transfer is taken while it is
// still stalled downstream.
module midpoint_ellipse_quadrant #(
    parameter int unsigned AXIS_MAX = meq_pkg::AXIS_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  meq_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output meq_pkg::t_out_item  o_out_data
);

    logic               core_ready;
    logic               res_valid;
    logic               slot_free;
    meq_pkg::t_out_item res;
    meq_pkg::t_mul_req  mul_req;
    meq_pkg::t_mul_rsp  mul_rsp;

    logic               r_out_valid;
    meq_pkg::t_out_item r_out_data;

    // Output slot can take a point when empty or being drained this cycle
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !core_ready;

    meq_core #(
        .AXIS_MAX (AXIS_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_in_valid && core_ready),
        .i_item      (i_in_data),
        .o_ready     (core_ready),
        .o_res_valid (res_valid),
        .i_res_take  (slot_free),
        .o_res       (res),
        .o_mul_req   (mul_req),
        .i_mul_rsp   (mul_rsp)
    );

    meq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // One-entry output register
    always_ff @(posedge i_clk) begin
        if (res_valid && slot_free) begin
            r_out_data <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/meq_mul.sv @@
// Shared signed multiplier with registered product and write-back tag.
module meq_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  meq_pkg::t_mul_req  i_req,
    output meq_pkg::t_mul_rsp  o_rsp
);

    logic signed [meq_pkg::PROD_W-1:0] r_prod;
    meq_pkg::t_wb                      r_tag;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.op_a * i_req.op_b;
        if (!i_rst_n) begin
            r_tag <= meq_pkg::WB_NONE;
        end else begin
            r_tag <= i_req.tag;
        end
    end

    assign o_rsp.prod = r_prod;
    assign o_rsp.tag  = r_tag;

endmodule

@@ rtl/meq_core.sv @@
// Sequencer and state registers of the midpoint ellipse stepper.
module meq_core #(
    parameter int unsigned AXIS_MAX = meq_pkg::AXIS_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  meq_pkg::t_in_item   i_item,
    output logic                o_ready,
    output logic                o_res_valid,
    input  logic                i_res_take,
    output meq_pkg::t_out_item  o_res,
    output meq_pkg::t_mul_req   o_mul_req,
    input  meq_pkg::t_mul_rsp   i_mul_rsp
);

    localparam int CW    = meq_pkg::COORD_W;
    localparam int CO_W  = CW + 3;
    localparam int MW    = meq_pkg::MUL_W;
    localparam int DW    = meq_pkg::DEC_W;
    localparam int unsigned SAT_LIM =
        (AXIS_MAX > meq_pkg::COORD_MAX) ? meq_pkg::COORD_MAX : AXIS_MAX;
    localparam logic [CW-1:0] LIM = CW'(SAT_LIM);
    localparam logic signed [CO_W-1:0] K1 = CO_W'(1);
    localparam logic signed [CO_W-1:0] K2 = CO_W'(2);
    localparam logic signed [CO_W-1:0] K3 = CO_W'(3);

    typedef enum logic [4:0] {
        S_IDLE, S_A2, S_B2, S_INIT,
        S_CMP1, S_CMP2, S_DECIDE, S_R1A, S_R1B,
        S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6, S_Q7,
        S_R2S, S_R2A, S_R2B, S_FIN, S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        REG_ONE, REG_TWO, REG_DONE
    } t_region;

    typedef enum logic [1:0] {
        K_START, K_R1, K_R2, K_DONE
    } t_kind;

    t_state                        r_state, n_state;
    t_region                       r_region, n_region;
    t_kind                         r_kind, n_kind;
    logic [CW-1:0]                 r_a, n_a, r_b, n_b, r_x, n_x, r_y, n_y;
    logic [meq_pkg::AX2_W-1:0]     r_a2, n_a2, r_b2, n_b2;
    logic [meq_pkg::SQ_W-1:0]      r_sq, n_sq;
    logic signed [DW-1:0]          r_dec, n_dec, r_tmp, n_tmp;
    logic                          r_dle, n_dle, r_last, n_last;

    logic signed [CO_W-1:0] x_s, y_s, b_s, x2, y2;
    logic signed [CO_W-1:0] tx1, tx2, tx3, ty1, ty2, ty3, ym1, tb;
    logic signed [MW-1:0]   a_op, b_op, a2_op, b2_op, sq_op;

    function automatic logic [CW-1:0] sat(input logic [CW-1:0] v);
        return (v > LIM) ? LIM : v;
    endfunction

    function automatic logic signed [MW-1:0] sx(input logic signed [CO_W-1:0] v);
        return MW'(v);
    endfunction

    assign x_s = $signed(CO_W'(r_x));
    assign y_s = $signed(CO_W'(r_y));
    assign b_s = $signed(CO_W'(r_b));
    assign x2  = x_s <<< 1;
    assign y2  = y_s <<< 1;
    assign tx1 = x2 + K1;
    assign tx2 = x2 + K2;
    assign tx3 = x2 + K3;
    assign ty1 = y2 - K1;
    assign ty2 = K2 - y2;
    assign ty3 = K3 - y2;
    assign ym1 = y_s - K1;
    assign tb  = K1 - (b_s <<< 2);

    assign a_op  = $signed(MW'(r_a));
    assign b_op  = $signed(MW'(r_b));
    assign a2_op = $signed(MW'(r_a2));
    assign b2_op = $signed(MW'(r_b2));
    assign sq_op = $signed(MW'(r_sq));

    always_comb begin
        n_state  = r_state;
        n_region = r_region;
        n_kind   = r_kind;
        n_a      = r_a;
        n_b      = r_b;
        n_x      = r_x;
        n_y      = r_y;
        n_a2     = r_a2;
        n_b2     = r_b2;
        n_sq     = r_sq;
        n_dec    = r_dec;
        n_tmp    = r_tmp;
        n_dle    = r_dle;
        n_last   = r_last;

        o_mul_req.op_a = '0;
        o_mul_req.op_b = '0;
        o_mul_req.tag  = meq_pkg::WB_NONE;

        // product write-back, in the cycle after issue
        case (i_mul_rsp.tag)
            meq_pkg::WB_A2:       n_a2  = i_mul_rsp.prod[meq_pkg::AX2_W-1:0];
            meq_pkg::WB_B2:       n_b2  = i_mul_rsp.prod[meq_pkg::AX2_W-1:0];
            meq_pkg::WB_DEC_INIT: n_dec = DW'(i_mul_rsp.prod) + (DW'(r_b2) << 2);
            meq_pkg::WB_TMP:      n_tmp = DW'(i_mul_rsp.prod);
            meq_pkg::WB_DEC_NEG4: n_dec = -(DW'(i_mul_rsp.prod) <<< 2);
            meq_pkg::WB_DEC_ADD:  n_dec = r_dec + DW'(i_mul_rsp.prod);
            meq_pkg::WB_DEC_ADD4: n_dec = r_dec + (DW'(i_mul_rsp.prod) <<< 2);
            meq_pkg::WB_SQ:       n_sq  = i_mul_rsp.prod[meq_pkg::SQ_W-1:0];
            default: ;
        endcase

        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_item.start_req) begin
                        n_a     = sat(i_item.semi_axis_x);
                        n_b     = sat(i_item.semi_axis_y);
                        n_x     = '0;
                        n_y     = sat(i_item.semi_axis_y);
                        n_kind  = K_START;
                        n_state = S_A2;
                    end else begin
                        n_kind  = K_DONE;
                        n_state = S_FIN;
                        if (r_y != '0) begin
                            case (r_region)
                                REG_ONE: n_state = S_CMP1;
                                REG_TWO: n_state = S_R2S;
                                default: ;
                            endcase
                        end
                    end
                end
            end
            S_A2: begin
                o_mul_req.op_a = a_op;
                o_mul_req.op_b = a_op;
                o_mul_req.tag  = meq_pkg::WB_A2;
                n_state        = S_B2;
            end
            S_B2: begin
                o_mul_req.op_a = b_op;
                o_mul_req.op_b = b_op;
                o_mul_req.tag  = meq_pkg::WB_B2;
                n_state        = S_INIT;
            end
            S_INIT: begin
                o_mul_req.op_a = a2_op;
                o_mul_req.op_b = sx(tb);
                o_mul_req.tag  = meq_pkg::WB_DEC_INIT;
                n_state        = S_FIN;
            end
            S_CMP1: begin
                o_mul_req.op_a = b2_op;
                o_mul_req.op_b = sx(tx2);
                o_mul_req.tag  = meq_pkg::WB_TMP;
                n_state        = S_CMP2;
            end
            S_CMP2: begin
                o_mul_req.op_a = a2_op;
                o_mul_req.op_b = sx(ty1);
                n_state        = S_DECIDE;
            end
            S_DECIDE: begin
                // 2b^2(x+1) against a^2(2y-1): stay in region 1 while below
                n_dle = (r_dec <= 0);
                if (r_tmp < DW'(i_mul_rsp.prod)) begin
                    n_kind  = K_R1;
                    n_state = S_R1A;
                end else begin
                    n_kind   = K_R2;
                    n_region = REG_TWO;
                    n_state  = S_Q1;
                end
            end
            S_R1A: begin
                o_mul_req.op_a = b2_op;
                o_mul_req.op_b = sx(tx3);
                o_mul_req.tag  = meq_pkg::WB_DEC_ADD4;
                n_state        = r_dle ? S_FIN : S_R1B;
            end
            S_R1B: begin
                o_mul_req.op_a = a2_op;
                o_mul_req.op_b = sx(ty2);
                o_mul_req.tag  = meq_pkg::WB_DEC_ADD4;
                n_state        = S_FIN;
            end
            S_Q1: begin
                o_mul_req.op_a = sx(tx1);
                o_mul_req.op_b = sx(tx1);
                o_mul_req.tag  = meq_pkg::WB_SQ;
                n_state        = S_Q2;
            end
            S_Q2: begin
                o_mul_req.op_a = a2_op;
                o_mul_req.op_b = b2_op;
                o_mul_req.tag  = meq_pkg::WB_DEC_NEG4;
                n_state        = S_Q3;
            end
            S_Q3: begin
                o_mul_req.op_a = b2_op;
                o_mul_req.op_b = sq_op;
                o_mul_req.tag  = meq_pkg::WB_DEC_ADD;
                n_state        = S_Q4;
            end
            S_Q4: begin
                o_mul_req.op_a = sx(ym1);
                o_mul_req.op_b = sx(ym1);
                o_mul_req.tag  = meq_pkg::WB_SQ;
                n_state        = S_Q5;
            end
            S_Q5: n_state = S_Q6;
            S_Q6: begin
                o_mul_req.op_a = a2_op;
                o_mul_req.op_b = sq_op;
                o_mul_req.tag  = meq_pkg::WB_DEC_ADD4;
                n_state        = S_Q7;
            end
            S_Q7: n_state = S_R2S;
            S_R2S: begin
                n_kind  = K_R2;
                n_dle   = (r_dec <= 0);
                n_state = S_R2A;
            end
            S_R2A: begin
                o_mul_req.op_a = a2_op;
                o_mul_req.op_b = sx(ty3);
                o_mul_req.tag  = meq_pkg::WB_DEC_ADD4;
                n_state        = r_dle ? S_R2B : S_FIN;
            end
            S_R2B: begin
                o_mul_req.op_a = b2_op;
                o_mul_req.op_b = sx(tx2);
                o_mul_req.tag  = meq_pkg::WB_DEC_ADD4;
                n_state        = S_FIN;
            end
            S_FIN: begin
                case (r_kind)
                    K_START: begin
                        n_last   = (r_y == '0);
                        n_region = (r_y == '0) ? REG_DONE : REG_ONE;
                    end
                    K_R1: begin
                        n_x = r_x + CW'(1);
                        if (!r_dle) begin
                            n_y = r_y - CW'(1);
                        end
                        n_last = (n_y == '0);
                        if (n_last) begin
                            n_region = REG_DONE;
                        end
                    end
                    K_R2: begin
                        if (r_dle) begin
                            n_x = r_x + CW'(1);
                        end
                        n_y    = r_y - CW'(1);
                        n_last = (n_y == '0);
                        if (n_last) begin
                            n_region = REG_DONE;
                        end
                    end
                    default: begin
                        n_last   = 1'b1;
                        n_region = REG_DONE;
                    end
                endcase
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_a2   <= n_a2;
        r_b2   <= n_b2;
        r_sq   <= n_sq;
        r_dec  <= n_dec;
        r_tmp  <= n_tmp;
        r_dle  <= n_dle;
        r_kind <= n_kind;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_region <= REG_DONE;
            r_x      <= '0;
            r_y      <= '0;
            r_last   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_region <= n_region;
            r_x      <= n_x;
            r_y      <= n_y;
            r_last   <= n_last;
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_PUSH);
    assign o_res.point_x   = r_x;
    assign o_res.point_y   = r_y;
    assign o_res.last      = r_last;

endmodule

@@ rtl/meq_chk.sv @@
// Port-level assertions for the ellipse quadrant block, bound to the top level.
`include "midpoint_ellipse_quadrant_macros.svh"

module meq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input meq_pkg::t_out_item o_out_data
);

    // last marks exactly the points on the x axis
    `MEQ_ASSERT(a_last_on_axis, o_out_valid |-> (o_out_data.last == (o_out_data.point_y == '0)), "last flag does not match point_y of zero")

    // one item in flight: input stalls right after a transfer
    `MEQ_ASSERT(a_stall_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall, "input not stalled after transfer")

    `MEQ_ASSERT_RST(a_rst_no_out, !i_rst_n |=> !o_out_valid, "output valid straight after reset")

    `MEQ_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "stalled output dropped or changed")

endmodule

bind midpoint_ellipse_quadrant meq_chk u_meq_chk (.*);

@@ bench/quadrant_point_check.sv @@
// Point checker for the ellipse quadrant generator: watches both channels, predicts, compares.
`timescale 1ns / 1ps

module quadrant_point_check #(
    parameter int unsigned AXIS_LIMIT = meq_pkg::AXIS_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  meq_pkg::t_in_item   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  meq_pkg::t_out_item  i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int CW = meq_pkg::COORD_W;

    typedef enum logic [1:0] {
        ARC_R1,
        ARC_R2,
        ARC_DONE,
        ARC_SPARE
    } t_arc_region;

    logic [CW-1:0]                    ax_a, ax_b, px, py;
    logic signed [meq_pkg::DEC_W-1:0] dval;
    t_arc_region                      arc;

    meq_pkg::t_out_item      due_points[$];
    int                      fails = 0;

    function automatic logic [CW-1:0] clip_axis(input logic [CW-1:0] v);
        int unsigned lim;
        lim = (AXIS_LIMIT > meq_pkg::COORD_MAX) ? meq_pkg::COORD_MAX : AXIS_LIMIT;
        return (v > lim) ? lim[CW-1:0] : v;
    endfunction

    // Next point of the walk; decision held at four times the textbook value
    task automatic plot_next(input meq_pkg::t_in_item itm, output meq_pkg::t_out_item pt);
        longint a2, b2, x, y, d;
        if (itm.start_req) begin
            ax_a = clip_axis(itm.semi_axis_x);
            ax_b = clip_axis(itm.semi_axis_y);
            a2   = longint'(ax_a) * longint'(ax_a);
            b2   = longint'(ax_b) * longint'(ax_b);
            px   = '0;
            py   = ax_b;
            d    = 4 * b2 + a2 * (1 - 4 * longint'(ax_b));
            dval = d[meq_pkg::DEC_W-1:0];
            arc  = (ax_b == 0) ? ARC_DONE : ARC_R1;
        end else if (arc == ARC_R1 || arc == ARC_R2) begin
            a2 = longint'(ax_a) * longint'(ax_a);
            b2 = longint'(ax_b) * longint'(ax_b);
            if (py == 0) begin
                arc = ARC_DONE;
            end else begin
                x = longint'(px);
                y = longint'(py);
                d = dval;
                if (arc == ARC_R1 && 2 * b2 * (x + 1) < a2 * (2 * y - 1)) begin
                    if (d <= 0) begin
                        d = d + 4 * b2 * (2 * x + 3);
                    end else begin
                        d  = d + 4 * (b2 * (2 * x + 3) + a2 * (2 - 2 * y));
                        py = py - CW'(1);
                    end
                    px = px + CW'(1);
                end else begin
                    // slope past -1: reload for region 2, step in the same item
                    if (arc == ARC_R1) begin
                        d   = b2 * (2 * x + 1) * (2 * x + 1)
                            + 4 * a2 * (y - 1) * (y - 1) - 4 * a2 * b2;
                        arc = ARC_R2;
                    end
                    if (d <= 0) begin
                        d  = d + 4 * (b2 * (2 * x + 2) + a2 * (3 - 2 * y));
                        px = px + CW'(1);
                    end else begin
                        d = d + 4 * a2 * (3 - 2 * y);
                    end
                    py = py - CW'(1);
                end
                dval = d[meq_pkg::DEC_W-1:0];
                if (py == 0) arc = ARC_DONE;
            end
        end
        pt.point_x = px;
        pt.point_y = py;
        pt.last    = (py == 0) || (arc > ARC_R2);
    endtask

    always @(posedge i_clk) begin : watch
        meq_pkg::t_out_item want;
        meq_pkg::t_out_item nxt;
        if (!i_rst_n) begin
            ax_a = '0;
            ax_b = '0;
            px   = '0;
            py   = '0;
            dval = '0;
            arc  = ARC_DONE;
            due_points.delete();
        end else begin
            // output side first: a result never belongs to an item taken at this edge
            if (i_out_valid && !i_out_stall) begin
                if (due_points.size() == 0) begin
                    $display("%0t: unexpected point (%0d,%0d) last %0d", $time,
                             i_out_data.point_x, i_out_data.point_y, i_out_data.last);
                    fails++;
                end else begin
                    want = due_points.pop_front();
                    if (i_out_data.point_x !== want.point_x) begin
                        $display("%0t: point_x expected %0d got %0d", $time,
                                 want.point_x, i_out_data.point_x);
                        fails++;
                    end
                    if (i_out_data.point_y !== want.point_y) begin
                        $display("%0t: point_y expected %0d got %0d", $time,
                                 want.point_y, i_out_data.point_y);
                        fails++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $display("%0t: last expected %0d got %0d", $time,
                                 want.last, i_out_data.last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                plot_next(i_in_data, nxt);
                due_points = {due_points, nxt};
            end
        end
        o_pending    <= due_points.size();
        o_fail_count <= fails;
    end

endmodule

@@ bench/testbench.sv @@
// Top of the ellipse quadrant bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int CW = meq_pkg::COORD_W;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    meq_pkg::t_in_item   i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    meq_pkg::t_out_item  o_out_data;

    int          fail_count;
    int          points_due;

    int          sent = 0;      // input transfers so far
    bit          burst = 1'b0;  // sender runs without gaps for the current walk

    always #5 i_clk = ~i_clk;

    midpoint_ellipse_quadrant dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    quadrant_point_check u_point_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (points_due)
    );

    // Idle length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 96) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 80));
    endfunction

    // Random axis value in a range
    function automatic logic [CW-1:0] rnd_axis(input int unsigned lo, input int unsigned hi);
        return CW'($urandom_range(hi, lo));
    endfunction

    // One input transfer. Valid stays high into the next item when there is
    // no gap, so it is never lowered and raised in the same step.
    task automatic send_item(input logic st, input logic [CW-1:0] ax,
                             input logic [CW-1:0] ay);
        int                gap;
        meq_pkg::t_in_item itm;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        itm.start_req   = st;
        itm.semi_axis_x = ax;
        itm.semi_axis_y = ay;
        i_in_valid <= 1'b1;
        i_in_data  <= itm;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    // Start transfer followed by a number of advances; noisy advances carry
    // random axis fields, which the block must ignore
    task automatic walk(input logic [CW-1:0] a, input logic [CW-1:0] b,
                        input int n_adv, input bit noisy);
        send_item(1'b1, a, b);
        repeat (n_adv) begin
            if (noisy)
                send_item(1'b0, rnd_axis(0, meq_pkg::COORD_MAX),
                          rnd_axis(0, meq_pkg::COORD_MAX));
            else
                send_item(1'b0, '0, '0);
        end
    endtask

    // Hold the sender until every outstanding point has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (points_due != 0);
    endtask

    // Receiver: flowing stretches (sometimes long) broken by stalls
    initial begin : sink
        int  n;
        bit  calm;
        forever begin
            calm = ($urandom_range(0, 9) == 0);
            n = int'($urandom_range(1, calm ? 200 : 12));
            i_out_stall <= 1'b0;
            repeat (n) @(posedge i_clk);
            n = idle_len();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Hard stop in case the handshake locks up
    initial begin : watchdog
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int             r, n;
        logic [CW-1:0]  a, b;
        bit             paused;
        paused = 1'b0;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // advances straight after reset repeat (0,0) with last
        send_item(1'b0, '0, '0);
        send_item(1'b0, '0, '0);
        // zero vertical axis: done at once
        walk(10'd0, 10'd0, 1, 1'b0);
        walk(10'd5, 10'd0, 1, 1'b0);
        // zero horizontal axis: straight down, then repeats past the end
        walk(10'd0, 10'd3, 4, 1'b0);
        // largest axes, a few steps into region 1
        walk(10'd1023, 10'd1023, 2, 1'b0);
        // flat and tall extremes: quick switch to region 2 for the tall one
        walk(10'd1023, 10'd1, 2, 1'b0);
        walk(10'd1, 10'd1023, 2, 1'b0);
        // small full ellipse crossing both regions, then repeats past the end
        walk(10'd3, 10'd2, 5, 1'b1);
        drain();

        // ---- random part ----
        while (sent < 1850) begin
            burst = ($urandom_range(0, 6) == 0);
            if (!paused && sent >= 900) begin
                drain();
                paused = 1'b1;
            end
            r = int'($urandom_range(0, 99));
            if (r < 70) begin
                // well-formed walk, mostly small axes, advances from the longer axis to both axes plus three
                a = ($urandom_range(0, 9) == 0) ? rnd_axis(41, 200) : rnd_axis(0, 40);
                b = ($urandom_range(0, 9) == 0) ? rnd_axis(41, 200) : rnd_axis(1, 40);
                n = int'((a > b) ? a : b);
                n = n + int'($urandom_range(0, ((a < b) ? a : b) + 3));
                walk(a, b, n, 1'b1);
            end else if (r < 85) begin
                // broken walk: any axes, cut short by the next start
                walk(rnd_axis(0, meq_pkg::COORD_MAX), rnd_axis(0, meq_pkg::COORD_MAX),
                     int'($urandom_range(0, 25)), 1'b1);
            end else if (r < 92) begin
                // degenerate axes
                if ($urandom_range(0, 1)) begin
                    b = rnd_axis(0, 60);
                    walk(10'd0, b, int'(b) + 2, 1'b1);
                end else begin
                    walk(rnd_axis(0, meq_pkg::COORD_MAX), 10'd0,
                         int'($urandom_range(0, 3)), 1'b1);
                end
            end else begin
                // near-maximum axes, short excursion
                case ($urandom_range(0, 2))
                    0: a = 10'd1023;
                    1: a = 10'd1022;
                    default: a = 10'd512;
                endcase
                b = $urandom_range(0, 1) ? 10'd1023 : rnd_axis(1, meq_pkg::COORD_MAX);
                if ($urandom_range(0, 1)) walk(a, b, int'($urandom_range(0, 40)), 1'b1);
                else walk(b, a, int'($urandom_range(0, 40)), 1'b1);
            end
        end

        // ---- wind-down ----
        drain();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && points_due == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/meq_pkg.sv
rtl/meq_mul.sv
rtl/meq_core.sv
rtl/midpoint_ellipse_quadrant.sv
rtl/meq_chk.sv
bench/quadrant_point_check.sv
bench/testbench.sv
